// ===== hw/rtl/telnet_receive_filter_assert.svh =====
// ----------------------------------------------------------------------------
// Telnet receive filter assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef TELNET_RECEIVE_FILTER_ASSERT_SVH
`define TELNET_RECEIVE_FILTER_ASSERT_SVH

// Same-cycle implication.
`define TRF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("telnet filter check failed");

// Next-cycle implication.
`define TRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("telnet filter check failed");

`endif

// ===== hw/rtl/telrx_pkg.sv =====
// ----------------------------------------------------------------------------
// telrx_pkg
// Types and byte codes shared by the telnet receive filter.
// ----------------------------------------------------------------------------
package telrx_pkg;

    typedef logic [7:0] t_byte;

    localparam t_byte CODE_IAC  = 8'd255;
    localparam t_byte CODE_SB   = 8'd250;
    localparam t_byte CODE_NAWS = 8'd31;
    localparam t_byte CODE_NOP  = 8'd0;
    localparam t_byte CODE_CR   = 8'd13;
    localparam t_byte CODE_LF   = 8'd10;

    localparam logic [2:0] SKIP_CMD  = 3'd1;
    localparam logic [2:0] SKIP_NAWS = 3'd6;

    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_AFTER_CR = 3'd1,
        MODE_IAC      = 3'd2,
        MODE_IAC_SB   = 3'd3,
        MODE_SKIP     = 3'd4
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [2:0] skip_left;
        logic       was_subneg;
    } t_parse_state;

endpackage

// ===== hw/rtl/telrx_parse.sv =====
// ----------------------------------------------------------------------------
// telrx_parse
// Per-byte command parser: next parse state and pass decision for one beat.
// ----------------------------------------------------------------------------
module telrx_parse (
    input  telrx_pkg::t_parse_state i_state,
    input  telrx_pkg::t_byte        i_byte,
    output telrx_pkg::t_parse_state o_state,
    output logic                    o_pass,
    output telrx_pkg::t_byte        o_data
);
    import telrx_pkg::*;

    // Next state.
    always_comb begin
        o_state = i_state;
        case (i_state.mode)
            MODE_AFTER_CR: begin
                if (i_byte == CODE_LF || i_byte == CODE_NOP) begin
                    o_state.mode = MODE_NORMAL;
                end else if (i_byte == CODE_IAC) begin
                    o_state.mode = MODE_IAC;
                end else if (i_byte == CODE_CR) begin
                    o_state.mode = MODE_AFTER_CR;
                end else begin
                    o_state.mode = MODE_NORMAL;
                end
            end
            MODE_IAC: begin
                if (i_byte == CODE_NOP || i_byte == CODE_IAC) begin
                    o_state.mode = MODE_NORMAL;
                end else if (i_byte == CODE_SB) begin
                    o_state.mode = MODE_IAC_SB;
                end else begin
                    o_state.mode       = MODE_SKIP;
                    o_state.skip_left  = SKIP_CMD;
                    o_state.was_subneg = 1'b0;
                end
            end
            MODE_IAC_SB: begin
                if (i_byte == CODE_NAWS) begin
                    o_state.mode       = MODE_SKIP;
                    o_state.skip_left  = SKIP_NAWS;
                    o_state.was_subneg = 1'b1;
                end else begin
                    o_state.mode       = MODE_NORMAL;
                    o_state.skip_left  = 3'd0;
                    o_state.was_subneg = 1'b0;
                end
            end
            MODE_SKIP: begin
                if (i_state.skip_left <= 3'd1) begin
                    o_state.mode       = MODE_NORMAL;
                    o_state.skip_left  = 3'd0;
                    o_state.was_subneg = 1'b0;
                end else begin
                    o_state.skip_left = i_state.skip_left - 3'd1;
                end
            end
            default: begin
                if (i_byte == CODE_IAC) begin
                    o_state.mode = MODE_IAC;
                end else if (i_byte == CODE_CR) begin
                    o_state.mode = MODE_AFTER_CR;
                end else begin
                    o_state.mode = MODE_NORMAL;
                end
            end
        endcase
    end

    // Pass decision; a doubled IAC already carries 255 on the input.
    always_comb begin
        o_data = i_byte;
        case (i_state.mode)
            MODE_AFTER_CR: o_pass = !(i_byte == CODE_LF || i_byte == CODE_NOP
                                      || i_byte == CODE_IAC);
            MODE_IAC:      o_pass = (i_byte == CODE_IAC);
            MODE_IAC_SB:   o_pass = 1'b0;
            MODE_SKIP:     o_pass = 1'b0;
            default:       o_pass = (i_byte != CODE_IAC);
        endcase
    end

endmodule

// ===== hw/rtl/telnet_receive_filter.sv =====
// ----------------------------------------------------------------------------
// telnet_receive_filter
// Strips telnet commands from a received byte stream, passing user data only.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and sends on only user data: IAC commands,
// the NAWS subnegotiation (nine bytes) and a LF or NUL right after CR are
// dropped, and IAC IAC becomes one 255. A byte is accepted every clock while
// the skid register is empty; a passed byte is registered into the result
// register, or the skid register while the output is stalled. The parse state
// is a single register updated each beat, which sets the one-byte-per-clock
// figure. A two-entry output stage (result register plus skid register) keeps
// input flowing when output stalls; ready drops only while skid holds a byte.
module telnet_receive_filter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  telrx_pkg::t_byte  s_axis_tdata,   // [7:0] rx_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output telrx_pkg::t_byte  m_axis_tdata    // [7:0] data_byte
);
    import telrx_pkg::*;

    t_parse_state r_state;
    t_parse_state n_state;
    logic         w_pass;
    t_byte        w_data;
    logic         w_accept;

    logic         r_out_valid;
    t_byte        r_out_data;
    logic         r_skid_valid;
    t_byte        r_skid_data;

    telrx_parse u_parse (
        .i_state (r_state),
        .i_byte  (s_axis_tdata),
        .o_state (n_state),
        .o_pass  (w_pass),
        .o_data  (w_data)
    );

    assign s_axis_tready = !r_skid_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode       <= MODE_NORMAL;
            r_state.skip_left  <= 3'd0;
            r_state.was_subneg <= 1'b0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                // Input is held; drain skid into the output slot.
                if (m_axis_tready) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (w_accept && w_pass) begin
                if (r_out_valid && !m_axis_tready) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out_data <= r_skid_data;
            end
        end else if (w_accept && w_pass) begin
            if (r_out_valid && !m_axis_tready) begin
                r_skid_data <= w_data;
            end else begin
                r_out_data <= w_data;
            end
        end
    end

`include "telnet_receive_filter_assert.svh"

    `TRF_ASSERT_NOW(a_skid_implies_out, r_skid_valid, r_out_valid)
    `TRF_ASSERT_NOW(a_subneg_in_skip, r_state.was_subneg, r_state.mode == MODE_SKIP)
    `TRF_ASSERT_NOW(a_skip_count_live, r_state.mode == MODE_SKIP, r_state.skip_left != 3'd0)
    `TRF_ASSERT_NEXT(a_stall_fills_skid,
        w_accept && w_pass && r_out_valid && !m_axis_tready, r_skid_valid)
    `TRF_ASSERT_NEXT(a_pass_shows_out, w_accept && w_pass, r_out_valid)

endmodule
